// ===== design/eztq_pkg.sv =====
// ----------------------------------------------------------------------------
// eztq_pkg
// Shared types and constants for the Euler Z-Y-X to quaternion pipeline.
// ----------------------------------------------------------------------------
package eztq_pkg;

  localparam int CORD_W = 34;   // CORDIC x/y/z width, units of 2^-30
  localparam int SC_W   = 22;   // sine/cosine width, units of 2^-20
  localparam int NUM_ANG = 3;   // 0 yaw, 1 pitch, 2 roll

  localparam logic signed [CORD_W-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [CORD_W-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
    logic                     neg;
  } lane_t;

  typedef lane_t [NUM_ANG-1:0] lanes_t;

  // restoring long division, used only while building the atan constants
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in units of 2^-30, from the truncated series; elaboration only
  function automatic logic signed [63:0] atan_pow2(int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int sgn;
    sum = 64'sd0;
    sgn = 1;
    if (i == 0) begin
      return 64'sd843314857;
    end
    for (int k = 1; i * k <= 62; k += 2) begin
      term = $signed(udiv64(64'd1 << (62 - i * k), 64'(k)));
      sum  = (sgn > 0) ? sum + term : sum - term;
      sgn  = -sgn;
    end
    return (sum + (64'sd1 <<< 31)) >>> 32;
  endfunction

endpackage

// ===== design/euler_zyx_to_quaternion.sv =====
// Request to result: input register, CORDIC cell registers, quaternion stages.
// Throughput: one request per cycle; the whole pipeline advances together and
// stalls only while a finished result waits at the output.
// Reset: synchronous active-low rst_n clears the valid bits; no other state.
// ----------------------------------------------------------------------------
// euler_zyx_to_quaternion
// Half-angle CORDIC cell chain followed by quaternion product stages.
// ----------------------------------------------------------------------------
module euler_zyx_to_quaternion #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int QUAT_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ANGLE_WIDTH-1:0] in_yaw_angle,
  input  logic signed [ANGLE_WIDTH-1:0] in_pitch_angle,
  input  logic signed [ANGLE_WIDTH-1:0] in_roll_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [QUAT_WIDTH-1:0]  out_quat_w,
  output logic signed [QUAT_WIDTH-1:0]  out_quat_x,
  output logic signed [QUAT_WIDTH-1:0]  out_quat_y,
  output logic signed [QUAT_WIDTH-1:0]  out_quat_z
);

  localparam int CW = eztq_pkg::CORD_W;

  logic en;
  logic signed [ANGLE_WIDTH-1:0] ang [eztq_pkg::NUM_ANG];

  logic             vld_r;
  eztq_pkg::lanes_t lanes_r, lanes_nxt;

  logic             vld_c   [CORDIC_STAGES+1];
  eztq_pkg::lanes_t lanes_c [CORDIC_STAGES+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign ang[0] = in_yaw_angle;
  assign ang[1] = in_pitch_angle;
  assign ang[2] = in_roll_angle;

  // half angle in 2^-30 rad, folded into [-pi/2, pi/2]
  always_comb begin
    for (int j = 0; j < eztq_pkg::NUM_ANG; j++) begin
      logic signed [CW-1:0] z;
      z = CW'(ang[j]) <<< (32 - ANGLE_WIDTH);
      lanes_nxt[j].neg = 1'b0;
      if (z > eztq_pkg::ANG_HALF_PI) begin
        z = z - eztq_pkg::ANG_PI;
        lanes_nxt[j].neg = 1'b1;
      end else if (z < -eztq_pkg::ANG_HALF_PI) begin
        z = z + eztq_pkg::ANG_PI;
        lanes_nxt[j].neg = 1'b1;
      end
      lanes_nxt[j].z = z;
      lanes_nxt[j].x = eztq_pkg::CORDIC_GAIN;
      lanes_nxt[j].y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign vld_c[0]   = vld_r;
  assign lanes_c[0] = lanes_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    eztq_cell #(.STAGE(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .vld_in    (vld_c[i]),
      .lanes_in  (lanes_c[i]),
      .vld_out   (vld_c[i+1]),
      .lanes_out (lanes_c[i+1])
    );
  end

  eztq_quat #(.QUAT_WIDTH(QUAT_WIDTH)) u_quat (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (vld_c[CORDIC_STAGES]),
    .lanes_in (lanes_c[CORDIC_STAGES]),
    .vld_out  (out_valid),
    .quat_w   (out_quat_w),
    .quat_x   (out_quat_x),
    .quat_y   (out_quat_y),
    .quat_z   (out_quat_z)
  );

endmodule

// ===== design/eztq_cell.sv =====
// ----------------------------------------------------------------------------
// eztq_cell
// One CORDIC rotation step for all three angles, registered.
// ----------------------------------------------------------------------------
module eztq_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  eztq_pkg::lanes_t lanes_in,
  output logic            vld_out,
  output eztq_pkg::lanes_t lanes_out
);

  localparam logic signed [63:0] ATAN64 = eztq_pkg::atan_pow2(STAGE);
  localparam logic signed [eztq_pkg::CORD_W-1:0] ATAN = ATAN64[eztq_pkg::CORD_W-1:0];

  logic             vld_r;
  eztq_pkg::lanes_t lanes_r, lanes_nxt;

  always_comb begin
    for (int j = 0; j < eztq_pkg::NUM_ANG; j++) begin
      logic signed [eztq_pkg::CORD_W-1:0] dx;
      logic signed [eztq_pkg::CORD_W-1:0] dy;
      dx = $signed(lanes_in[j].y) >>> STAGE;
      dy = $signed(lanes_in[j].x) >>> STAGE;
      lanes_nxt[j].neg = lanes_in[j].neg;
      if (!lanes_in[j].z[eztq_pkg::CORD_W-1]) begin
        lanes_nxt[j].x = lanes_in[j].x - dx;
        lanes_nxt[j].y = lanes_in[j].y + dy;
        lanes_nxt[j].z = lanes_in[j].z - ATAN;
      end else begin
        lanes_nxt[j].x = lanes_in[j].x + dx;
        lanes_nxt[j].y = lanes_in[j].y - dy;
        lanes_nxt[j].z = lanes_in[j].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign lanes_out = lanes_r;

endmodule

// ===== design/eztq_quat.sv =====
// ----------------------------------------------------------------------------
// eztq_quat
// Sine/cosine rounding, triple products, rounding and saturation.
// ----------------------------------------------------------------------------
module eztq_quat #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_in,
  input  eztq_pkg::lanes_t             lanes_in,
  output logic                         vld_out,
  output logic signed [QUAT_WIDTH-1:0] quat_w,
  output logic signed [QUAT_WIDTH-1:0] quat_x,
  output logic signed [QUAT_WIDTH-1:0] quat_y,
  output logic signed [QUAT_WIDTH-1:0] quat_z
);

  localparam int SC_W = eztq_pkg::SC_W;
  localparam int CW   = eztq_pkg::CORD_W;
  localparam int PW   = 2 * SC_W;
  localparam int TW   = 3 * SC_W;
  localparam int SW   = TW + 1;
  localparam int FRAC = QUAT_WIDTH - 2;
  localparam int SH   = 60 - FRAC;
  localparam logic signed [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} <<< (SH - 1);
  localparam logic signed [SW-1:0] LIM = {{(SW-1){1'b0}}, 1'b1} <<< FRAC;

  logic [3:0] vld_r;

  // stage 1: sin/cos per angle
  logic signed [SC_W-1:0] c_r [eztq_pkg::NUM_ANG];
  logic signed [SC_W-1:0] s_r [eztq_pkg::NUM_ANG];
  // stage 2: pair products crcp, srsp, srcp, crsp
  logic signed [PW-1:0] p_r [4];
  logic signed [SC_W-1:0] cy_r, sy_r;
  // stage 3: triple products
  logic signed [TW-1:0] t_r [8];
  // stage 4: outputs
  logic signed [QUAT_WIDTH-1:0] q_r [4];
  logic signed [QUAT_WIDTH-1:0] q_nxt [4];

  function automatic logic signed [QUAT_WIDTH-1:0] finish(logic signed [SW-1:0] sum);
    logic signed [SW-1:0] v;
    v = (sum + RND) >>> SH;
    if (v > LIM) begin
      v = LIM;
    end else if (v < -LIM) begin
      v = -LIM;
    end
    return v[QUAT_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < eztq_pkg::NUM_ANG; j++) begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = lanes_in[j].neg ? -lanes_in[j].x : lanes_in[j].x;
        ys = lanes_in[j].neg ? -lanes_in[j].y : lanes_in[j].y;
        xs = xs + 34'sd512;
        ys = ys + 34'sd512;
        c_r[j] <= xs[SC_W+9:10];
        s_r[j] <= ys[SC_W+9:10];
      end
      // index 0 yaw, 1 pitch, 2 roll
      p_r[0] <= c_r[2] * c_r[1];
      p_r[1] <= s_r[2] * s_r[1];
      p_r[2] <= s_r[2] * c_r[1];
      p_r[3] <= c_r[2] * s_r[1];
      cy_r   <= c_r[0];
      sy_r   <= s_r[0];
      t_r[0] <= p_r[0] * cy_r;
      t_r[1] <= p_r[1] * sy_r;
      t_r[2] <= p_r[2] * cy_r;
      t_r[3] <= p_r[3] * sy_r;
      t_r[4] <= p_r[3] * cy_r;
      t_r[5] <= p_r[2] * sy_r;
      t_r[6] <= p_r[0] * sy_r;
      t_r[7] <= p_r[1] * cy_r;
      for (int k = 0; k < 4; k++) begin
        q_r[k] <= q_nxt[k];
      end
    end
  end

  always_comb begin
    q_nxt[0] = finish(SW'(t_r[0]) + SW'(t_r[1]));
    q_nxt[1] = finish(SW'(t_r[2]) - SW'(t_r[3]));
    q_nxt[2] = finish(SW'(t_r[4]) + SW'(t_r[5]));
    q_nxt[3] = finish(SW'(t_r[6]) - SW'(t_r[7]));
  end

  assign vld_out = vld_r[3];
  assign quat_w  = q_r[0];
  assign quat_x  = q_r[1];
  assign quat_y  = q_r[2];
  assign quat_z  = q_r[3];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for euler_zyx_to_quaternion: drives yaw/pitch/roll
// requests through a valid/ready channel with random gaps and stalls, and
// compares every quaternion against a bit-accurate half-angle CORDIC model.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_yaw_angle = '0;
  logic signed [15:0] in_pitch_angle = '0;
  logic signed [15:0] in_roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;

  euler_zyx_to_quaternion uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_yaw_angle(in_yaw_angle), .in_pitch_angle(in_pitch_angle),
    .in_roll_angle(in_roll_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z)
  );

  always #10 clk = ~clk;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 300;

  quat_t quat_queue[$];
  longint atan_tab[0:31];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;

  // atan(2^-i), alternating series truncated to 2^-62, rounded to 2^-30
  function automatic longint atan_step(int i);
    longint acc;
    longint term;
    int sgn;
    acc = 0;
    sgn = 1;
    if (i == 0) return 64'sd843314857;
    for (int k = 1; i * k <= 62; k += 2) begin
      term = (longint'(1) <<< (62 - i * k)) / k;
      acc = (sgn > 0) ? acc + term : acc - term;
      sgn = -sgn;
    end
    return (acc + (longint'(1) <<< 31)) >>> 32;
  endfunction

  // sine and cosine of half the angle, units of 2^-20
  task automatic half_trig(input logic signed [15:0] ang, output longint s, output longint c);
    longint zz, xx, yy, dx, dy;
    bit flip;
    zz = longint'(ang) * 65536;
    xx = longint'(eztq_pkg::CORDIC_GAIN);
    yy = 0;
    flip = 1'b0;
    if (zz > longint'(eztq_pkg::ANG_HALF_PI)) begin
      zz -= longint'(eztq_pkg::ANG_PI);
      flip = 1'b1;
    end else if (zz < -longint'(eztq_pkg::ANG_HALF_PI)) begin
      zz += longint'(eztq_pkg::ANG_PI);
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      if (zz >= 0) begin
        xx -= dx; yy += dy; zz -= atan_tab[i];
      end else begin
        xx += dx; yy -= dy; zz += atan_tab[i];
      end
    end
    if (flip) begin
      xx = -xx; yy = -yy;
    end
    c = (xx + 512) >>> 10;
    s = (yy + 512) >>> 10;
  endtask

  function automatic logic signed [15:0] to_q14(longint acc);
    longint v;
    v = (acc + (longint'(1) <<< 45)) >>> 46;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  task automatic predict_quat(input angles_t a, output quat_t q);
    longint sy, cy, sp, cp, sr, cr;
    half_trig(a.yaw, sy, cy);
    half_trig(a.pitch, sp, cp);
    half_trig(a.roll, sr, cr);
    q.w = to_q14(cr * cp * cy + sr * sp * sy);
    q.x = to_q14(sr * cp * cy - cr * sp * sy);
    q.y = to_q14(cr * sp * cy + sr * cp * sy);
    q.z = to_q14(cr * cp * sy - sr * sp * cy);
  endtask

  // monitor: predict on request accept, check on result accept, watchdog
  always @(posedge clk) begin
    angles_t a;
    quat_t q, exp_q;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        a.yaw = in_yaw_angle; a.pitch = in_pitch_angle; a.roll = in_roll_angle;
        predict_quat(a, q);
        quat_queue.push_back(q);
      end
      if (out_valid && out_ready) begin
        if (quat_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                   out_quat_w, out_quat_x, out_quat_y, out_quat_z);
        end else begin
          exp_q = quat_queue.pop_front();
          n_checked++;
          if (out_quat_w !== exp_q.w || out_quat_x !== exp_q.x ||
              out_quat_y !== exp_q.y || out_quat_z !== exp_q.z) begin
            errors++;
            $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                     out_quat_w, out_quat_x, out_quat_y, out_quat_z);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** euler_zyx_to_quaternion: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_cnt;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 0;
        out_ready <= 1'b0;
        while (hold_cnt < HOLDOFF_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_angles(input logic signed [15:0] yw, input logic signed [15:0] pt,
                             input logic signed [15:0] rl);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_yaw_angle <= yw;
    in_pitch_angle <= pt;
    in_roll_angle <= rl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic signed [15:0] rand_angle();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return 16'($urandom());
    if (pick < 8) return 16'(int'($urandom_range(0, 511)) - 256);
    if (pick == 8)
      return 16'(int'($urandom_range(25700, 25770)) * (($urandom_range(1) == 1) ? 1 : -1));
    return ($urandom_range(1) == 1) ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (quat_queue.size() != 0) @(posedge clk);
  endtask

  angles_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh7fff, 16'sh8000, 16'sd0},
    '{16'sd1, -16'sd1, 16'sd1},
    '{-16'sd1, 16'sd1, -16'sd1},
    '{16'sd25735, 16'sd0, 16'sd0},
    '{16'sd25736, 16'sd0, 16'sd0},
    '{-16'sd25735, 16'sd0, 16'sd0},
    '{-16'sd25736, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd25736, -16'sd25736},
    '{16'sd0, 16'sd12868, 16'sd0},
    '{16'sd12868, 16'sd12868, 16'sd12868},
    '{16'sh5555, 16'shaaaa, 16'sh5555},
    '{16'shaaaa, 16'sh5555, 16'shaaaa},
    '{16'sd6434, -16'sd6434, 16'sd6434},
    '{16'sh7fff, 16'sd25736, 16'sh8000},
    '{16'sd0, 16'sd0, 16'sh7fff}
  };

  initial begin
    for (int i = 0; i < 32; i++) atan_tab[i] = atan_step(i);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, no idling
    foreach (directed[i]) send_angles(directed[i].yaw, directed[i].pitch, directed[i].roll);
    drain();

    random_burst(200);

    // long receiver hold-off while the sender keeps pushing requests
    hold_req = 1;
    random_burst(60);
    drain();
    repeat (40) @(posedge clk);

    send_idle_pct = 55;
    random_burst(250);
    send_idle_pct = 0;
    recv_stall_pct = 55;
    random_burst(250);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    random_burst(250);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_burst(40);

    drain();
    repeat (30) @(posedge clk);
    $display("Covered %0d requests (%0d checked): angle extremes, half-pi fold edges,", n_sent,
             n_checked);
    $display("saturation, random gaps/stalls and a %0d-cycle output hold-off.", HOLDOFF_CYCLES);
    if (errors == 0 && quat_queue.size() == 0) begin
      $display("** euler_zyx_to_quaternion: PASSED **");
    end else begin
      $display("** euler_zyx_to_quaternion: FAILED **");
    end
    $finish;
  end

endmodule

// ===== euler_zyx_to_quaternion.f =====
design/eztq_pkg.sv
design/eztq_cell.sv
design/eztq_quat.sv
design/euler_zyx_to_quaternion.sv
test/tb.sv
